// ----- hdl/i2c_master_byte_engine_core_assert.svh -----
// ----------------------------------------------------------------------------
// I2C byte engine assertion macros
// Shared property wrappers, clocked on clk and held off during arst_n.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define I2CME_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define I2CME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/i2cme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C byte engine package
// Shared widths, opcodes, register indexes and the request/result types.
// ----------------------------------------------------------------------------
package i2cme_pkg;

	localparam int CNT_W     = 16;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	// request opcodes
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// timing register indexes
	localparam logic [REG_IDX_W-1:0] REG_SETUP_DATA  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_DATA   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_START  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SETUP_START = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SETUP_STOP  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BUS_FREE    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LOW_PERIOD  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_PERIOD = 3'd7;

	// timing register reset values
	localparam logic [CNT_W-1:0] RST_SETUP_DATA  = 16'd25;
	localparam logic [CNT_W-1:0] RST_HOLD_DATA   = 16'd30;
	localparam logic [CNT_W-1:0] RST_HOLD_START  = 16'd400;
	localparam logic [CNT_W-1:0] RST_SETUP_START = 16'd470;
	localparam logic [CNT_W-1:0] RST_SETUP_STOP  = 16'd400;
	localparam logic [CNT_W-1:0] RST_BUS_FREE    = 16'd470;
	localparam logic [CNT_W-1:0] RST_LOW_PERIOD  = 16'd470;
	localparam logic [CNT_W-1:0] RST_HIGH_PERIOD = 16'd400;

	typedef struct packed {
		logic [CNT_W-1:0] setup_data;
		logic [CNT_W-1:0] hold_data;
		logic [CNT_W-1:0] hold_start;
		logic [CNT_W-1:0] setup_start;
		logic [CNT_W-1:0] setup_stop;
		logic [CNT_W-1:0] bus_free;
		logic [CNT_W-1:0] low_period;
		logic [CNT_W-1:0] high_period;
	} cfg_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] data_byte;
		logic       ack_reply;
		logic       sda_sample;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_received;
		logic       rejected;
	} result_t;

endpackage

// ----- hdl/i2c_master_byte_engine_core.sv -----
`timescale 1ns / 1ps
// Path: an accepted request is held in the input register, then its result in the result register behind m_tvalid.
// Throughput: one request per cycle; the input register, the sequencer and the
// result register each take one request a cycle, stalling only on m_tready.
// Reset (arst_n low, asynchronous): both streams empty, timing registers at their
// defaults, sequencer idle with SCL and SDA released high.
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-sequenced I2C master: tick, start, stop, write byte and read byte requests,
// one result per request.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_core_assert.svh"

module i2c_master_byte_engine_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// request stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,  // [7:0] data_byte, [8] ack_reply, [9] sda_sample
	input  logic [2:0]                   s_tuser,  // [2:0] opcode
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [15:0]                  m_tdata,  // [0] scl_level, [1] sda_level, [2] busy_res,
	                                               // [3] done_res, [11:4] read_data,
	                                               // [12] ack_received, [13] rejected
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [i2cme_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	i2cme_pkg::cfg_t    cfg;
	i2cme_pkg::item_t   item_s1;
	i2cme_pkg::result_t res;
	logic               valid_s1;
	logic               advance;
	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;

	i2cme_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	i2cme_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (advance),
		.item   (item_s1),
		.res    (res)
	);

	// stage 1 moves on whenever the result register is free or draining
	assign advance  = valid_s1 & (~m_tvalid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.opcode     <= s_tuser;
			item_s1.data_byte  <= s_tdata[7:0];
			item_s1.ack_reply  <= s_tdata[8];
			item_s1.sda_sample <= s_tdata[9];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {2'b00, res.rejected, res.ack_received, res.read_data,
				res.done_res, res.busy_res, res.sda_level, res.scl_level};
		end
	end

	// checks
	`I2CME_ASSERT_NEXT(a_result_loaded, advance, m_tvalid, "processed request left no result")
	`I2CME_ASSERT_NEXT(a_stage_held, valid_s1 && m_tvalid && !m_tready, valid_s1, "stalled request dropped")
	`I2CME_ASSERT_NOW(a_done_not_rejected, advance, !(res.done_res && res.rejected), "rejected request finished a command")
	`I2CME_ASSERT_NOW(a_rejected_busy, advance && res.rejected, res.busy_res, "request rejected while idle")

endmodule

// ----- hdl/i2cme_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C byte engine timing registers
// APB-style register file holding the eight phase tick counts.
// ----------------------------------------------------------------------------
module i2cme_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [i2cme_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output i2cme_pkg::cfg_t              cfg
);

	logic                              wr_en;
	logic [i2cme_pkg::REG_IDX_W-1:0]   idx;
	logic [i2cme_pkg::CNT_W-1:0]       rd_val;
	i2cme_pkg::cfg_t                   cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[i2cme_pkg::ADDR_W-1:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setup_data  <= i2cme_pkg::RST_SETUP_DATA;
			cfg_q.hold_data   <= i2cme_pkg::RST_HOLD_DATA;
			cfg_q.hold_start  <= i2cme_pkg::RST_HOLD_START;
			cfg_q.setup_start <= i2cme_pkg::RST_SETUP_START;
			cfg_q.setup_stop  <= i2cme_pkg::RST_SETUP_STOP;
			cfg_q.bus_free    <= i2cme_pkg::RST_BUS_FREE;
			cfg_q.low_period  <= i2cme_pkg::RST_LOW_PERIOD;
			cfg_q.high_period <= i2cme_pkg::RST_HIGH_PERIOD;
		end else if (wr_en) begin
			case (idx)
				i2cme_pkg::REG_SETUP_DATA:  cfg_q.setup_data  <= pwdata[15:0];
				i2cme_pkg::REG_HOLD_DATA:   cfg_q.hold_data   <= pwdata[15:0];
				i2cme_pkg::REG_HOLD_START:  cfg_q.hold_start  <= pwdata[15:0];
				i2cme_pkg::REG_SETUP_START: cfg_q.setup_start <= pwdata[15:0];
				i2cme_pkg::REG_SETUP_STOP:  cfg_q.setup_stop  <= pwdata[15:0];
				i2cme_pkg::REG_BUS_FREE:    cfg_q.bus_free    <= pwdata[15:0];
				i2cme_pkg::REG_LOW_PERIOD:  cfg_q.low_period  <= pwdata[15:0];
				default:                    cfg_q.high_period <= pwdata[15:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			i2cme_pkg::REG_SETUP_DATA:  rd_val = cfg_q.setup_data;
			i2cme_pkg::REG_HOLD_DATA:   rd_val = cfg_q.hold_data;
			i2cme_pkg::REG_HOLD_START:  rd_val = cfg_q.hold_start;
			i2cme_pkg::REG_SETUP_START: rd_val = cfg_q.setup_start;
			i2cme_pkg::REG_SETUP_STOP:  rd_val = cfg_q.setup_stop;
			i2cme_pkg::REG_BUS_FREE:    rd_val = cfg_q.bus_free;
			i2cme_pkg::REG_LOW_PERIOD:  rd_val = cfg_q.low_period;
			default:                    rd_val = cfg_q.high_period;
		endcase
		prdata = {16'd0, rd_val};
	end

endmodule

// ----- hdl/i2cme_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C byte engine pin sequencer
// Phase state plus the next-state logic that runs zero-length phases through
// in the same request.
// ----------------------------------------------------------------------------
module i2cme_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2cme_pkg::cfg_t      cfg,
	input  logic                 fire,
	input  i2cme_pkg::item_t     item,
	output i2cme_pkg::result_t   res
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_FREE, PH_ST_SETUP, PH_RS_SDA, PH_RS_SCL, PH_ST_HOLD, PH_ST_END,
		PH_SP_LOW, PH_SP_SETUP, PH_SP_FREE,
		PH_WD_SET, PH_WD_HIGH, PH_WD_LOW,
		PH_WA_SET, PH_WA_H1, PH_WA_H2, PH_WA_LOW,
		PH_RD_SET, PH_RD_H1, PH_RD_H2, PH_RD_LOW,
		PH_RA_SET, PH_RA_HIGH, PH_RA_LOW
	} phase_t;

	typedef struct packed {
		phase_t     ph;
		logic [2:0] bit_idx;
		logic [7:0] shift;
		logic       started;
		logic       scl;
		logic       sda;
		logic       ack;
		logic       ack_send;
		logic [7:0] rd_latch;
		logic       done;
	} eng_t;

	// which timing registers are zero
	typedef struct packed {
		logic sd, hd, hs, ss, sp, bf, lp, hp, h1, h2;
	} zero_t;

	eng_t                        eng_q;
	logic [i2cme_pkg::CNT_W-1:0] cnt_q;
	eng_t                        cur, pre, chain, nxt;
	logic [i2cme_pkg::CNT_W-1:0] dec, cnt_nxt;
	logic                        run, rej, busy;
	zero_t                       z;
	logic                        zw, zr;

	function automatic logic is_zero(phase_t ph, zero_t zf);
		logic r;
		case (ph)
			PH_ST_FREE, PH_SP_FREE:            r = zf.bf;
			PH_ST_SETUP, PH_RS_SDA, PH_RS_SCL: r = zf.ss;
			PH_ST_HOLD:                        r = zf.hs;
			PH_SP_LOW:                         r = zf.lp;
			PH_SP_SETUP:                       r = zf.sp;
			PH_WD_SET, PH_WA_SET, PH_RD_SET, PH_RA_SET: r = zf.sd;
			PH_WD_HIGH, PH_RA_HIGH:            r = zf.hp;
			PH_WA_H1, PH_RD_H1:                r = zf.h1;
			PH_WA_H2, PH_RD_H2:                r = zf.h2;
			default:                           r = zf.hd;
		endcase
		return r;
	endfunction

	function automatic logic [i2cme_pkg::CNT_W-1:0] wait_of(phase_t ph, i2cme_pkg::cfg_t c);
		logic [i2cme_pkg::CNT_W-1:0] half;
		logic [i2cme_pkg::CNT_W-1:0] w;
		half = c.high_period >> 1;
		case (ph)
			PH_ST_FREE, PH_SP_FREE:            w = c.bus_free;
			PH_ST_SETUP, PH_RS_SDA, PH_RS_SCL: w = c.setup_start;
			PH_ST_HOLD:                        w = c.hold_start;
			PH_SP_LOW:                         w = c.low_period;
			PH_SP_SETUP:                       w = c.setup_stop;
			PH_WD_SET, PH_WA_SET, PH_RD_SET, PH_RA_SET: w = c.setup_data;
			PH_WD_HIGH, PH_RA_HIGH:            w = c.high_period;
			PH_WA_H1, PH_RD_H1:                w = half;
			PH_WA_H2, PH_RD_H2:                w = c.high_period - half;
			default:                           w = c.hold_data;
		endcase
		return w;
	endfunction

	// pin and data effects on entering a phase
	function automatic eng_t enter_ph(eng_t e, logic sda_in);
		case (e.ph)
			PH_ST_SETUP: begin
				e.scl = 1'b1;
				e.sda = 1'b1;
			end
			PH_RS_SDA, PH_SP_FREE: e.sda = 1'b1;
			PH_RS_SCL, PH_SP_SETUP, PH_WD_HIGH, PH_WA_H1, PH_RD_H1, PH_RA_HIGH: e.scl = 1'b1;
			PH_ST_HOLD: e.sda = 1'b0;
			PH_ST_END, PH_WD_LOW, PH_WA_LOW, PH_RD_LOW, PH_RA_LOW: e.scl = 1'b0;
			PH_SP_LOW: begin
				e.scl = 1'b0;
				e.sda = 1'b0;
			end
			PH_WD_SET: begin
				e.scl = 1'b0;
				e.sda = e.shift[3'd7 - e.bit_idx];
			end
			PH_WA_SET, PH_RD_SET: begin
				e.scl = 1'b0;
				e.sda = 1'b1;
			end
			PH_WA_H2: e.ack = ~sda_in;
			PH_RD_H2: e.shift = {e.shift[6:0], sda_in};
			PH_RA_SET: begin
				e.scl = 1'b0;
				e.sda = ~e.ack_send;
			end
			default: e.done = e.done;
		endcase
		return e;
	endfunction

	// successor phase, bumping the bit index at the end of a data bit
	function automatic eng_t next_of(eng_t e);
		case (e.ph)
			PH_ST_FREE:              e.ph = PH_ST_SETUP;
			PH_ST_SETUP, PH_RS_SCL:  e.ph = PH_ST_HOLD;
			PH_RS_SDA:               e.ph = PH_RS_SCL;
			PH_ST_HOLD:              e.ph = PH_ST_END;
			PH_SP_LOW:               e.ph = PH_SP_SETUP;
			PH_SP_SETUP:             e.ph = PH_SP_FREE;
			PH_WD_LOW: begin
				if (e.bit_idx != 3'd7) begin
					e.bit_idx = e.bit_idx + 3'd1;
					e.ph = PH_WD_SET;
				end else begin
					e.ph = PH_WA_SET;
				end
			end
			PH_RD_LOW: begin
				if (e.bit_idx != 3'd7) begin
					e.bit_idx = e.bit_idx + 3'd1;
					e.ph = PH_RD_SET;
				end else begin
					e.ph = PH_RA_SET;
				end
			end
			PH_WD_SET:  e.ph = PH_WD_HIGH;
			PH_WD_HIGH: e.ph = PH_WD_LOW;
			PH_WA_SET:  e.ph = PH_WA_H1;
			PH_WA_H1:   e.ph = PH_WA_H2;
			PH_WA_H2:   e.ph = PH_WA_LOW;
			PH_RD_SET:  e.ph = PH_RD_H1;
			PH_RD_H1:   e.ph = PH_RD_H2;
			PH_RD_H2:   e.ph = PH_RD_LOW;
			PH_RA_SET:  e.ph = PH_RA_HIGH;
			PH_RA_HIGH: e.ph = PH_RA_LOW;
			default:    e.ph = PH_IDLE;
		endcase
		return e;
	endfunction

	function automatic eng_t finish(eng_t e);
		if (e.ph == PH_ST_END) begin
			e.started = 1'b1;
		end else if (e.ph == PH_SP_FREE) begin
			e.started = 1'b0;
		end else if (e.ph == PH_RA_LOW) begin
			e.rd_latch = e.shift;
		end
		e.ph   = PH_IDLE;
		e.done = 1'b1;
		return e;
	endfunction

	function automatic eng_t advance(eng_t e, logic sda_in);
		eng_t n;
		n = next_of(e);
		if (n.ph == PH_IDLE) begin
			n = finish(e);
		end else begin
			n = enter_ph(n, sda_in);
		end
		return n;
	endfunction

	// when every phase of the bit loop is zero length, jump past the
	// remaining bits; a read still shifts in one sample per skipped bit
	function automatic eng_t skip_loop(eng_t e, logic zwr, logic zrd, logic sda_in);
		logic [3:0]  k;
		logic [15:0] ext;
		k   = 4'd0;
		ext = 16'd0;
		if (zwr && (e.ph == PH_WD_SET || e.ph == PH_WD_HIGH || e.ph == PH_WD_LOW)) begin
			e.bit_idx = 3'd7;
			e.ph      = PH_WA_SET;
		end else if (zrd && (e.ph == PH_RD_SET || e.ph == PH_RD_H1 ||
				e.ph == PH_RD_H2 || e.ph == PH_RD_LOW)) begin
			if (e.ph == PH_RD_LOW) begin
				k = 4'd7 - {1'b0, e.bit_idx};
			end else begin
				k = 4'd8 - {1'b0, e.bit_idx};
			end
			ext       = {e.shift, {8{sda_in}}} << k;
			e.shift   = ext[15:8];
			e.bit_idx = 3'd7;
			e.ph      = PH_RA_SET;
		end
		return e;
	endfunction

	// zero flags of the timing registers
	always_comb begin
		z.sd = (cfg.setup_data  == '0);
		z.hd = (cfg.hold_data   == '0);
		z.hs = (cfg.hold_start  == '0);
		z.ss = (cfg.setup_start == '0);
		z.sp = (cfg.setup_stop  == '0);
		z.bf = (cfg.bus_free    == '0);
		z.lp = (cfg.low_period  == '0);
		z.hp = (cfg.high_period == '0);
		z.h1 = (cfg.high_period[i2cme_pkg::CNT_W-1:1] == '0);
		z.h2 = z.hp;
		zw   = z.sd & z.hp & z.hd;
		zr   = z.sd & z.hp & z.hd;
	end

	// next state for the request in the input register
	always_comb begin
		cur      = eng_q;
		cur.done = 1'b0;
		busy     = (cur.ph != PH_IDLE);
		nxt      = cur;
		pre      = cur;
		chain    = cur;
		run      = 1'b0;
		rej      = 1'b0;
		dec      = cnt_q - {{(i2cme_pkg::CNT_W-1){1'b0}}, |cnt_q};
		cnt_nxt  = cnt_q;

		if (item.opcode == i2cme_pkg::OP_TICK) begin
			if (busy) begin
				if (dec != '0) begin
					cnt_nxt = dec;
				end else begin
					pre = next_of(cur);
					if (pre.ph == PH_IDLE) begin
						nxt     = finish(cur);
						cnt_nxt = '0;
					end else begin
						run = 1'b1;
					end
				end
			end
		end else if (item.opcode <= i2cme_pkg::OP_READ) begin
			if (busy) begin
				rej = 1'b1;
			end else begin
				run         = 1'b1;
				pre.bit_idx = 3'd0;
				case (item.opcode)
					i2cme_pkg::OP_START: pre.ph = cur.started ? PH_RS_SDA : PH_ST_FREE;
					i2cme_pkg::OP_STOP:  pre.ph = PH_SP_LOW;
					i2cme_pkg::OP_WRITE: begin
						pre.shift = item.data_byte;
						pre.ph    = PH_WD_SET;
					end
					default: begin
						pre.shift    = 8'd0;
						pre.ack_send = item.ack_reply;
						pre.ph       = PH_RD_SET;
					end
				endcase
			end
		end

		// run through zero-length phases
		if (run) begin
			chain = skip_loop(pre, zw, zr, item.sda_sample);
			chain = enter_ph(chain, item.sda_sample);
			for (int i = 0; i < 8; i++) begin
				if (chain.ph != PH_IDLE && is_zero(chain.ph, z)) begin
					chain = advance(chain, item.sda_sample);
				end
			end
			nxt     = chain;
			cnt_nxt = (chain.ph == PH_IDLE) ? '0 : wait_of(chain.ph, cfg);
		end

		res.scl_level    = nxt.scl;
		res.sda_level    = nxt.sda;
		res.busy_res     = (nxt.ph != PH_IDLE);
		res.done_res     = nxt.done;
		res.read_data    = nxt.rd_latch;
		res.ack_received = nxt.ack;
		res.rejected     = rej;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q <= '{ph: PH_IDLE, bit_idx: 3'd0, shift: 8'd0, started: 1'b0,
				scl: 1'b1, sda: 1'b1, ack: 1'b0, ack_send: 1'b0,
				rd_latch: 8'd0, done: 1'b0};
			cnt_q <= '0;
		end else if (fire) begin
			eng_q <= nxt;
			cnt_q <= cnt_nxt;
		end
	end

endmodule
